>>> design/fbs_pkg.sv
// ----------------------------------------------------------------------------
// fbs_pkg
// Shared types and constants of the floppy block-to-sector sequencer.
// ----------------------------------------------------------------------------
package fbs_pkg;

  // Configuration register indexes.
  localparam logic CFG_MAPPED_BLOCKS = 1'b0;
  localparam logic CFG_RAW_BLOCKS    = 1'b1;

  // Reset block counts of the two unit kinds.
  localparam logic [8:0] MAPPED_BLOCKS_RST = 9'd494;
  localparam logic [8:0] RAW_BLOCKS_RST    = 9'd500;

  // Result status codes.
  localparam logic [1:0] ST_ADDR  = 2'd0;
  localparam logic [1:0] ST_ERR   = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // Geometry.
  localparam int unsigned MAX_SECTORS       = 64;
  localparam int unsigned SECTORS_PER_TRACK = 26;
  localparam int unsigned HALF_TRACK        = 13;
  localparam int unsigned TRACK_SKEW        = 6;
  localparam int unsigned LAST_TRACK        = 76;

  // Reciprocal of 26 scaled by 2^16, exact for dividends below 6553.
  localparam int unsigned RECIP_26     = 2521;
  // The same reciprocal premultiplied by the track skew.
  localparam int unsigned RECIP_26_X6  = RECIP_26 * TRACK_SKEW;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture the request beat
    logic quot;        // first quotient: starting track
    logic rem;         // starting sector and skew quotient
    logic skew;        // starting skew
    logic emit_err;    // issue an error result
    logic emit_empty;  // issue an empty result
    logic emit_sec;    // issue a sector address and advance
  } fbs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic reject;      // negative block or unit too small
    logic empty;       // no whole sector asked for
    logic too_many;    // more sectors than the limit
    logic trk_over;    // current sector falls past the last track
    logic last_sec;    // current sector is the final one
  } fbs_stat_t;

endpackage

>>> design/fbs_ctrl.sv
// ----------------------------------------------------------------------------
// fbs_ctrl
// Controller of the sequencer: checks a request, sets up the starting
// position, then steps through the sectors one per cycle.
// ----------------------------------------------------------------------------
module fbs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  fbs_pkg::fbs_stat_t stat,
  output fbs_pkg::fbs_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_SKEW  = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign busy = (state_r != S_IDLE);

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.quot = 1'b1;
        if (stat.reject) begin
          cmd.emit_err = 1'b1;
          state_nxt    = S_IDLE;
        end else if (stat.empty) begin
          cmd.emit_empty = 1'b1;
          state_nxt      = S_IDLE;
        end else if (stat.too_many) begin
          cmd.emit_err = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.rem   = 1'b1;
        state_nxt = S_SKEW;
      end
      S_SKEW: begin
        cmd.skew  = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (stat.trk_over) begin
          cmd.emit_err = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          cmd.emit_sec = 1'b1;
          if (stat.last_sec) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> design/fbs_datapath.sv
// ----------------------------------------------------------------------------
// fbs_datapath
// Request registers, unit size registers, the track and sector counters and
// the registered result outputs.
// ----------------------------------------------------------------------------
module fbs_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [8:0]         cfg_wdata,
  input  logic [1:0]         in_unit,
  input  logic signed [15:0] in_block_number,
  input  logic [14:0]        in_word_count,
  input  logic               in_is_write,
  input  fbs_pkg::fbs_cmd_t  cmd,
  output fbs_pkg::fbs_stat_t stat,
  output logic               out_strobe,
  output logic               out_drive_select,
  output logic               out_write_op,
  output logic [6:0]         out_track,
  output logic [4:0]         out_sector,
  output logic [12:0]        out_byte_offset,
  output logic               out_last,
  output logic [1:0]         out_status
);

  // Unit sizes.
  logic [8:0] mapped_blocks_r;
  logic [8:0] raw_blocks_r;

  // Request.
  logic [1:0]  unit_r;
  logic [15:0] blk_r;
  logic [14:0] words_r;
  logic        wr_r;

  // Position.
  logic [6:0] q1_r;   // starting track
  logic [4:0] q2_r;   // floor(6 * track / 26)
  logic [6:0] t_r;    // logical track
  logic [4:0] s_r;    // sector within logical track
  logic [4:0] sk_r;   // 6 * track mod 26
  logic [5:0] i_r;    // place in request

  // Outputs.
  logic        strobe_r;
  logic        drive_r;
  logic        wop_r;
  logic [6:0]  track_r;
  logic [4:0]  sector_r;
  logic [12:0] offset_r;
  logic        last_r;
  logic [1:0]  status_r;

  logic        mapped;
  logic [8:0]  size;
  logic [16:0] blk_end;
  logic [8:0]  nsect;
  logic [10:0] lsn0;
  logic [22:0] q1_prod;
  logic [20:0] q2_prod;
  logic [10:0] s0;
  logic [8:0]  sk0;
  logic [6:0]  track_val;
  logic [6:0]  phys_sum;
  logic [4:0]  phys;
  logic [4:0]  sector_val;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mapped_blocks_r <= fbs_pkg::MAPPED_BLOCKS_RST;
      raw_blocks_r    <= fbs_pkg::RAW_BLOCKS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fbs_pkg::CFG_MAPPED_BLOCKS: mapped_blocks_r <= cfg_wdata;
        fbs_pkg::CFG_RAW_BLOCKS:    raw_blocks_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Request checks.
  assign mapped  = ~unit_r[1];
  assign size    = mapped ? mapped_blocks_r : raw_blocks_r;
  assign blk_end = {1'b0, blk_r} + {10'd0, words_r[14:8]};
  assign nsect   = words_r[14:6];

  assign stat.reject   = blk_r[15] | (blk_end > {8'd0, size});
  assign stat.empty    = (nsect == 9'd0);
  assign stat.too_many = (nsect > 9'(fbs_pkg::MAX_SECTORS));

  // Division of the starting sector number by 26 through a reciprocal.
  // In the accepted range the block is below 512, so the number fits 11 bits.
  assign lsn0    = {blk_r[8:0], 2'b00};
  assign q1_prod = 23'(lsn0) * 23'(fbs_pkg::RECIP_26);
  assign q2_prod = 21'(q1_r) * 21'(fbs_pkg::RECIP_26_X6);
  assign s0      = lsn0 - 11'(q1_r) * 11'(fbs_pkg::SECTORS_PER_TRACK);
  assign sk0     = 9'(t_r) * 9'(fbs_pkg::TRACK_SKEW)
                 - 9'(q2_r) * 9'(fbs_pkg::SECTORS_PER_TRACK);

  // Physical address of the current sector.
  assign track_val = mapped ? (t_r + 7'd1) : t_r;
  assign phys_sum  = 7'({s_r, 1'b0}) + 7'(s_r >= 5'(fbs_pkg::HALF_TRACK)) + 7'(sk_r);

  always_comb begin
    priority if (phys_sum >= 7'(2 * fbs_pkg::SECTORS_PER_TRACK)) begin
      phys = 5'(phys_sum - 7'(2 * fbs_pkg::SECTORS_PER_TRACK));
    end else if (phys_sum >= 7'(fbs_pkg::SECTORS_PER_TRACK)) begin
      phys = 5'(phys_sum - 7'(fbs_pkg::SECTORS_PER_TRACK));
    end else begin
      phys = phys_sum[4:0];
    end
  end

  assign sector_val    = (mapped ? phys : s_r) + 5'd1;
  assign stat.trk_over = (track_val > 7'(fbs_pkg::LAST_TRACK));
  assign stat.last_sec = ((9'(i_r) + 9'd1) == nsect);

  // Request capture and position setup and stepping.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      unit_r  <= in_unit;
      blk_r   <= in_block_number;
      words_r <= in_word_count;
      wr_r    <= in_is_write;
    end
    if (cmd.quot) begin
      q1_r <= q1_prod[22:16];
    end
    if (cmd.rem) begin
      t_r  <= q1_r;
      s_r  <= s0[4:0];
      q2_r <= q2_prod[20:16];
      i_r  <= '0;
    end
    if (cmd.skew) begin
      sk_r <= sk0[4:0];
    end
    if (cmd.emit_sec) begin
      i_r <= i_r + 6'd1;
      if (s_r == 5'(fbs_pkg::SECTORS_PER_TRACK - 1)) begin
        s_r <= '0;
        t_r <= t_r + 7'd1;
        if (sk_r >= 5'(fbs_pkg::SECTORS_PER_TRACK - fbs_pkg::TRACK_SKEW)) begin
          sk_r <= sk_r - 5'(fbs_pkg::SECTORS_PER_TRACK - fbs_pkg::TRACK_SKEW);
        end else begin
          sk_r <= sk_r + 5'(fbs_pkg::TRACK_SKEW);
        end
      end else begin
        s_r <= s_r + 5'd1;
      end
    end
  end

  // Result strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= cmd.emit_err | cmd.emit_empty | cmd.emit_sec;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (cmd.emit_err || cmd.emit_empty || cmd.emit_sec) begin
      drive_r <= unit_r[0];
      wop_r   <= wr_r;
    end
    priority if (cmd.emit_sec) begin
      track_r  <= track_val;
      sector_r <= sector_val;
      offset_r <= {i_r, 7'd0};
      last_r   <= stat.last_sec;
      status_r <= fbs_pkg::ST_ADDR;
    end else if (cmd.emit_err || cmd.emit_empty) begin
      track_r  <= '0;
      sector_r <= '0;
      offset_r <= '0;
      last_r   <= 1'b1;
      status_r <= cmd.emit_err ? fbs_pkg::ST_ERR : fbs_pkg::ST_EMPTY;
    end
  end

  assign out_strobe       = strobe_r;
  assign out_drive_select = drive_r;
  assign out_write_op     = wop_r;
  assign out_track        = track_r;
  assign out_sector       = sector_r;
  assign out_byte_offset  = offset_r;
  assign out_last         = last_r;
  assign out_status       = status_r;

endmodule

>>> design/floppy_block_to_sector_sequencer.sv
// A rejected or empty request gives its one result from the check state.
// A request of N sectors passes the check, division and skew states, then gives
// one address per cycle and stays busy, taking no start, until its last result.
// The setup steps through the reciprocal divisions by 26 before the sector walk.
// Reset is synchronous and active low; it restores the unit sizes to 494 and 500.
// ----------------------------------------------------------------------------
// floppy_block_to_sector_sequencer
// Expands a block transfer request into one physical floppy address per
// 128-byte sector, with interleave and skew on the mapped units.
// ----------------------------------------------------------------------------
module floppy_block_to_sector_sequencer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [8:0]         cfg_wdata,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_unit,
  input  logic signed [15:0] in_block_number,
  input  logic [14:0]        in_word_count,
  input  logic               in_is_write,
  output logic               out_strobe,
  output logic               out_drive_select,
  output logic               out_write_op,
  output logic [6:0]         out_track,
  output logic [4:0]         out_sector,
  output logic [12:0]        out_byte_offset,
  output logic               out_last,
  output logic [1:0]         out_status
);

  fbs_pkg::fbs_cmd_t  cmd;
  fbs_pkg::fbs_stat_t stat;

  // Sequencing control.
  fbs_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // Counters, checks and result registers.
  fbs_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_unit          (in_unit),
    .in_block_number  (in_block_number),
    .in_word_count    (in_word_count),
    .in_is_write      (in_is_write),
    .cmd              (cmd),
    .stat             (stat),
    .out_strobe       (out_strobe),
    .out_drive_select (out_drive_select),
    .out_write_op     (out_write_op),
    .out_track        (out_track),
    .out_sector       (out_sector),
    .out_byte_offset  (out_byte_offset),
    .out_last         (out_last),
    .out_status       (out_status)
  );

  // Error and empty results always close the request.
  a_nonaddr_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_status != fbs_pkg::ST_ADDR)) |-> out_last)
    else $error("error or empty result without last mark");

  // Sector addresses stay inside the disk geometry.
  a_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_status == fbs_pkg::ST_ADDR)) |->
      ((out_sector >= 5'd1) && (out_sector <= 5'd26) && (out_track <= 7'd76)))
    else $error("sector address outside the disk geometry");

  // An accepted request keeps the block busy.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  // No result may follow the last one of a request in the next cycle.
  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_last) |=> !out_strobe)
    else $error("result directly after the last result");

endmodule
